FILE: design/psd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// shared widths, part codes and stage payload types of the point to
// segment distance pipeline
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int COORD_BITS   = 24;
   localparam int DIFF_W       = COORD_BITS + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int SQ_W         = 2 * COORD_BITS + 2;
   localparam int SUM_W        = SQ_W + 1;
   localparam int HALF_W       = SQ_W / 2;
   localparam int NUM_W        = 2 * SQ_W;
   localparam int QB           = SQ_W;
   localparam int RB           = SQ_W / 2;
   localparam int REM_W        = RB + 2;
   localparam int DIST_W       = 25;
   localparam int FRONT_STAGES = 6;
   localparam int PIPE_DEPTH   = FRONT_STAGES + QB + 1 + RB;

   localparam logic [1:0] PART_START = 2'd0;
   localparam logic [1:0] PART_END   = 2'd1;
   localparam logic [1:0] PART_INNER = 2'd2;
   localparam logic [1:0] PART_NONE  = 2'd3;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [1:0]      part;
      logic [SQ_W-1:0] d2;
   } side_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [SQ_W-1:0]  divisor;
      side_type         side;
   } div_req_type;

   typedef struct packed {
      logic [QB-1:0] quot;
      side_type      side;
   } div_rsp_type;

endpackage

FILE: design/psd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_front
// differences, dot products, nearest part decision and the wide numerator
// |w|^2*c2 - c1^2, six register stages
// ----------------------------------------------------------------------------
module psd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  psd_pkg::coord_type   point_in [3],
   input  psd_pkg::coord_type   start_in [3],
   input  psd_pkg::coord_type   end_in   [3],
   output logic                 out_valid,
   output psd_pkg::div_req_type out_data
);
   import psd_pkg::*;

   logic vld_ff [FRONT_STAGES];

   // stage 1: differences
   logic signed [DIFF_W-1:0] w_in [3], v_in [3], u_in [3];
   logic signed [DIFF_W-1:0] w_ff [3], v_ff [3], u_ff [3];

   // stage 2: coordinate products
   logic signed [PROD_W-1:0] ww_in [3], wv_in [3], vv_in [3], uu_in [3];
   logic signed [PROD_W-1:0] ww_ff [3], wv_ff [3], vv_ff [3], uu_ff [3];

   // stage 3: dot products
   logic signed [SUM_W-1:0] sww_in, sc1_in, sc2_in, suu_in;
   logic signed [SUM_W-1:0] sww_ff, sc1_ff, sc2_ff, suu_ff;

   // stage 4: decision and partial products
   logic [SQ_W-1:0] a_w, b_w, c_w;
   logic [1:0]      part_in;
   logic [SQ_W-1:0] d2_in;
   logic [SQ_W-1:0] ab_hh_in, ab_hl_in, ab_lh_in, ab_ll_in, cc_hh_in, cc_hl_in, cc_ll_in;
   logic [SQ_W-1:0] ab_hh_ff, ab_hl_ff, ab_lh_ff, ab_ll_ff, cc_hh_ff, cc_hl_ff, cc_ll_ff;
   side_type        side4_ff;
   logic [SQ_W-1:0] dvs4_ff;

   // stage 5: full products
   logic [NUM_W-1:0] pa_in, pc_in, pa_ff, pc_ff;
   side_type         side5_ff;
   logic [SQ_W-1:0]  dvs5_ff;

   // stage 6: numerator
   div_req_type      out_in, out_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         w_in[i] = DIFF_W'(point_in[i]) - DIFF_W'(start_in[i]);
         v_in[i] = DIFF_W'(end_in[i])   - DIFF_W'(start_in[i]);
         u_in[i] = DIFF_W'(point_in[i]) - DIFF_W'(end_in[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ww_in[i] = w_ff[i] * w_ff[i];
         wv_in[i] = w_ff[i] * v_ff[i];
         vv_in[i] = v_ff[i] * v_ff[i];
         uu_in[i] = u_ff[i] * u_ff[i];
      end
   end

   always_comb begin
      sww_in = SUM_W'(ww_ff[0]) + SUM_W'(ww_ff[1]) + SUM_W'(ww_ff[2]);
      sc1_in = SUM_W'(wv_ff[0]) + SUM_W'(wv_ff[1]) + SUM_W'(wv_ff[2]);
      sc2_in = SUM_W'(vv_ff[0]) + SUM_W'(vv_ff[1]) + SUM_W'(vv_ff[2]);
      suu_in = SUM_W'(uu_ff[0]) + SUM_W'(uu_ff[1]) + SUM_W'(uu_ff[2]);
   end

   always_comb begin
      a_w = sww_ff[SQ_W-1:0];
      b_w = sc2_ff[SQ_W-1:0];
      c_w = sc1_ff[SQ_W-1:0];
      if (sc1_ff[SUM_W-1] || (sc1_ff == '0)) begin
         part_in = PART_START;
         d2_in   = a_w;
      end else if (sc2_ff <= sc1_ff) begin
         part_in = PART_END;
         d2_in   = suu_ff[SQ_W-1:0];
      end else begin
         part_in = PART_INNER;
         d2_in   = a_w;
      end
      ab_hh_in = a_w[SQ_W-1:HALF_W] * b_w[SQ_W-1:HALF_W];
      ab_hl_in = a_w[SQ_W-1:HALF_W] * b_w[HALF_W-1:0];
      ab_lh_in = a_w[HALF_W-1:0]    * b_w[SQ_W-1:HALF_W];
      ab_ll_in = a_w[HALF_W-1:0]    * b_w[HALF_W-1:0];
      cc_hh_in = c_w[SQ_W-1:HALF_W] * c_w[SQ_W-1:HALF_W];
      cc_hl_in = c_w[SQ_W-1:HALF_W] * c_w[HALF_W-1:0];
      cc_ll_in = c_w[HALF_W-1:0]    * c_w[HALF_W-1:0];
   end

   always_comb begin
      pa_in = (NUM_W'(ab_hh_ff) << (2 * HALF_W)) + (NUM_W'(ab_hl_ff) << HALF_W)
            + (NUM_W'(ab_lh_ff) << HALF_W) + NUM_W'(ab_ll_ff);
      pc_in = (NUM_W'(cc_hh_ff) << (2 * HALF_W)) + (NUM_W'(cc_hl_ff) << (HALF_W + 1))
            + NUM_W'(cc_ll_ff);
   end

   always_comb begin
      out_in.num     = pa_ff - pc_ff;
      out_in.divisor = dvs5_ff;
      out_in.side    = side5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FRONT_STAGES; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < FRONT_STAGES; k++) vld_ff[k] <= vld_ff[k-1];
      end
      w_ff      <= w_in;
      v_ff      <= v_in;
      u_ff      <= u_in;
      ww_ff     <= ww_in;
      wv_ff     <= wv_in;
      vv_ff     <= vv_in;
      uu_ff     <= uu_in;
      sww_ff    <= sww_in;
      sc1_ff    <= sc1_in;
      sc2_ff    <= sc2_in;
      suu_ff    <= suu_in;
      ab_hh_ff  <= ab_hh_in;
      ab_hl_ff  <= ab_hl_in;
      ab_lh_ff  <= ab_lh_in;
      ab_ll_ff  <= ab_ll_in;
      cc_hh_ff  <= cc_hh_in;
      cc_hl_ff  <= cc_hl_in;
      cc_ll_ff  <= cc_ll_in;
      side4_ff  <= '{part: part_in, d2: d2_in};
      dvs4_ff   <= b_w;
      pa_ff     <= pa_in;
      pc_ff     <= pc_in;
      side5_ff  <= side4_ff;
      dvs5_ff   <= dvs4_ff;
      out_ff    <= out_in;
   end

   assign out_valid = vld_ff[FRONT_STAGES-1];
   assign out_data  = out_ff;

endmodule

FILE: design/psd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module psd_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  psd_pkg::div_req_type in_data,
   output logic                 out_valid,
   output psd_pkg::div_rsp_type out_data
);
   import psd_pkg::*;

   logic             vld_ff  [QB];
   logic [NUM_W-1:0] rq_in   [QB];
   logic [NUM_W-1:0] rq_ff   [QB];
   logic [SQ_W-1:0]  dvs_ff  [QB];
   side_type         side_ff [QB];

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic             vld_cur;
      logic [NUM_W-1:0] rq_cur;
      logic [SQ_W-1:0]  dvs_cur;
      side_type         side_cur;
      logic [SQ_W:0]    trial;
      logic [SQ_W:0]    rem;
      logic             ge;

      if (k == 0) begin : g_first
         assign vld_cur  = in_valid;
         assign rq_cur   = in_data.num;
         assign dvs_cur  = in_data.divisor;
         assign side_cur = in_data.side;
      end else begin : g_next
         assign vld_cur  = vld_ff[k-1];
         assign rq_cur   = rq_ff[k-1];
         assign dvs_cur  = dvs_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      always_comb begin
         trial    = {rq_cur[NUM_W-1:QB], rq_cur[QB-1]};
         ge       = (trial >= {1'b0, dvs_cur});
         rem      = ge ? (trial - {1'b0, dvs_cur}) : trial;
         rq_in[k] = {rem[SQ_W-1:0], rq_cur[QB-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_cur;
         end
         rq_ff[k]   <= rq_in[k];
         dvs_ff[k]  <= dvs_cur;
         side_ff[k] <= side_cur;
      end
   end

   assign out_valid     = vld_ff[QB-1];
   assign out_data.quot = rq_ff[QB-1][QB-1:0];
   assign out_data.side = side_ff[QB-1];

endmodule

FILE: design/psd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_sqrt
// pipelined floor integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module psd_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [psd_pkg::SQ_W-1:0]   in_rad,
   input  logic [1:0]                 in_part,
   output logic                       out_valid,
   output logic [psd_pkg::RB-1:0]     out_root,
   output logic [1:0]                 out_part
);
   import psd_pkg::*;

   logic             vld_ff  [RB];
   logic [SQ_W-1:0]  rad_ff  [RB];
   logic [REM_W-1:0] rem_in  [RB];
   logic [REM_W-1:0] rem_ff  [RB];
   logic [RB-1:0]    root_in [RB];
   logic [RB-1:0]    root_ff [RB];
   logic [1:0]       part_ff [RB];

   for (genvar k = 0; k < RB; k++) begin : g_stage
      logic             vld_cur;
      logic [SQ_W-1:0]  rad_cur;
      logic [REM_W-1:0] rem_cur;
      logic [RB-1:0]    root_cur;
      logic [1:0]       part_cur;
      logic [REM_W+1:0] t;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      logic             ge;

      if (k == 0) begin : g_first
         assign vld_cur  = in_valid;
         assign rad_cur  = in_rad;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign part_cur = in_part;
      end else begin : g_next
         assign vld_cur  = vld_ff[k-1];
         assign rad_cur  = rad_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign part_cur = part_ff[k-1];
      end

      always_comb begin
         t          = {rem_cur, rad_cur[SQ_W-1:SQ_W-2]};
         trial      = (REM_W + 2)'({root_cur, 2'b01});
         ge         = (t >= trial);
         diff       = ge ? (t - trial) : t;
         rem_in[k]  = diff[REM_W-1:0];
         root_in[k] = {root_cur[RB-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_cur;
         end
         rad_ff[k]  <= {rad_cur[SQ_W-3:0], 2'b00};
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         part_ff[k] <= part_cur;
      end
   end

   assign out_valid = vld_ff[RB-1];
   assign out_root  = root_ff[RB-1];
   assign out_part  = part_ff[RB-1];

endmodule

FILE: design/point_segment_distance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_core
// floor distance from a 3d point to a segment and the nearest part
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   req_point_*, req_start_*,      start, busy (accepted on start
//            req_end_*                      and not busy)
//  result    rsp_distance, rsp_nearest_part rsp_valid, one cycle each
//
//  one request per cycle; PIPE_DEPTH sums six front
//  stages, one stage per quotient bit of the divider (50), one select stage
//  and one stage per root bit (25). busy stays low.
//  reset clears only the valid bits; the result side cannot stall.
// ----------------------------------------------------------------------------
module point_segment_distance_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [psd_pkg::COORD_BITS-1:0] req_point_x,
   input  logic signed [psd_pkg::COORD_BITS-1:0] req_point_y,
   input  logic signed [psd_pkg::COORD_BITS-1:0] req_point_z,
   input  logic signed [psd_pkg::COORD_BITS-1:0] req_start_x,
   input  logic signed [psd_pkg::COORD_BITS-1:0] req_start_y,
   input  logic signed [psd_pkg::COORD_BITS-1:0] req_start_z,
   input  logic signed [psd_pkg::COORD_BITS-1:0] req_end_x,
   input  logic signed [psd_pkg::COORD_BITS-1:0] req_end_y,
   input  logic signed [psd_pkg::COORD_BITS-1:0] req_end_z,
   output logic                             rsp_valid,
   output logic [psd_pkg::DIST_W-1:0]       rsp_distance,
   output logic [1:0]                       rsp_nearest_part
);
   import psd_pkg::*;

   coord_type   point_w [3], start_w [3], end_w [3];
   logic        front_valid, div_valid, sq_valid;
   div_req_type front_data;
   div_rsp_type div_data;
   logic [RB-1:0] sq_root;
   logic [1:0]    sq_part;

   logic            pick_vld_ff;
   logic [SQ_W-1:0] pick_d2_in, pick_d2_ff;
   logic [1:0]      pick_part_ff;

   assign busy = 1'b0;

   assign point_w = '{req_point_x, req_point_y, req_point_z};
   assign start_w = '{req_start_x, req_start_y, req_start_z};
   assign end_w   = '{req_end_x, req_end_y, req_end_z};

   psd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .point_in  (point_w),
      .start_in  (start_w),
      .end_in    (end_w),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   psd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   // interior takes the quotient, endpoints their squared distance to the point
   assign pick_d2_in = (div_data.side.part == PART_INNER) ? div_data.quot : div_data.side.d2;

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_vld_ff <= 1'b0;
      end else begin
         pick_vld_ff <= div_valid;
      end
      pick_d2_ff   <= pick_d2_in;
      pick_part_ff <= div_data.side.part;
   end

   psd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pick_vld_ff),
      .in_rad    (pick_d2_ff),
      .in_part   (pick_part_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_part  (sq_part)
   );

   assign rsp_valid        = sq_valid;
   assign rsp_distance     = DIST_W'(sq_root);
   assign rsp_nearest_part = sq_part;

endmodule

FILE: design/psd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_checker
// port level checks of the distance core, bound to the top level
// ----------------------------------------------------------------------------
module psd_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_nearest_part
);
   import psd_pkg::*;

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_request_answered : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH rsp_valid)
      else $error("request without result");

   a_result_requested : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result without request");

   a_part_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_nearest_part != PART_NONE))
      else $error("bad nearest part code");

endmodule

bind point_segment_distance_core psd_checker u_psd_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_nearest_part (rsp_nearest_part)
);

FILE: verif/tb_point_segment_distance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_segment_distance_core
// self-checking bench for the point to segment distance core: directed corner
// requests, then random segments in bursts, each result checked in order
// against an exact integer prediction of distance and nearest part
// ----------------------------------------------------------------------------
module tb_point_segment_distance_core;
   import psd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = PIPE_DEPTH + 20;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic [1:0]        part;
   } dist_result_type;

   int error_count;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // exact prediction; 200-bit signed values cover every intermediate
   function automatic dist_result_type predict_distance(input coord_type c[9]);
      logic signed [199:0] w[3], v[3], u[3];
      logic signed [199:0] c1, c2, ww, d2, num;
      logic [199:0] root, trial;
      dist_result_type r;
      for (int i = 0; i < 3; i++) begin
         w[i] = 200'(c[i]) - 200'(c[3+i]);
         v[i] = 200'(c[6+i]) - 200'(c[3+i]);
         u[i] = 200'(c[i]) - 200'(c[6+i]);
      end
      c1 = w[0]*v[0] + w[1]*v[1] + w[2]*v[2];
      ww = w[0]*w[0] + w[1]*w[1] + w[2]*w[2];
      c2 = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
      if (c1 <= 0) begin
         d2 = ww; r.part = PART_START;
      end else if (c2 <= c1) begin
         d2 = u[0]*u[0] + u[1]*u[1] + u[2]*u[2]; r.part = PART_END;
      end else begin
         num = ww*c2 - c1*c1;
         d2 = num / c2; r.part = PART_INNER;
      end
      root = 0;
      for (int b = 39; b >= 0; b--) begin
         trial = root | (200'd1 << b);
         if (trial*trial <= d2) root = trial;
      end
      r.distance = root[DIST_W-1:0];
      return r;
   endfunction

   class distance_scoreboard;
      dist_result_type pending[$];
      int checked;
      function void note_request(coord_type c[9]);
         pending.push_back(predict_distance(c));
      endfunction
      task check_result(logic [DIST_W-1:0] d, logic [1:0] p);
         dist_result_type e;
         if (pending.size() == 0) begin
            report_mismatch("result with no request outstanding");
            return;
         end
         e = pending.pop_front();
         checked++;
         if (d !== e.distance)
            report_mismatch($sformatf("distance %0d, predicted %0d", d, e.distance));
         if (p !== e.part)
            report_mismatch($sformatf("nearest part %0d, predicted %0d", p, e.part));
      endtask
   endclass

   distance_scoreboard sb = new();

   logic clock = 0, reset = 1, start = 0, busy, rsp_valid;
   coord_type req_c[9];
   logic [DIST_W-1:0] rsp_distance;
   logic [1:0] rsp_nearest_part;
   int idle_cycles, sent;

   initial forever #5 clock = ~clock;

   initial for (int i = 0; i < 9; i++) req_c[i] = '0;

   point_segment_distance_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_point_x(req_c[0]), .req_point_y(req_c[1]), .req_point_z(req_c[2]),
      .req_start_x(req_c[3]), .req_start_y(req_c[4]), .req_start_z(req_c[5]),
      .req_end_x(req_c[6]), .req_end_y(req_c[7]), .req_end_z(req_c[8]),
      .rsp_valid(rsp_valid), .rsp_distance(rsp_distance),
      .rsp_nearest_part(rsp_nearest_part));

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_distance, rsp_nearest_part);
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog expired, nothing moved");
            $display("tb_point_segment_distance_core: done, errors");
            $finish;
         end
      end else idle_cycles <= 0;
   end

   // holds start across back-to-back requests; lowers it only on a gap
   task automatic send_request(input coord_type c[9], input bit last_in_burst);
      start <= 1;
      for (int i = 0; i < 9; i++) req_c[i] <= c[i];
      do @(posedge clock); while (busy);
      sb.note_request(c);
      sent++;
      if (last_in_burst) start <= 0;
   endtask

   function automatic coord_type rand_coord(input int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 15)) - 8;
         2: return ($urandom_range(0, 1)) ? 24'sh7fffff : 24'sh800000;
         default: return coord_type'($urandom_range(0, 2047)) - 1024;
      endcase
   endfunction

   task automatic send_directed();
      coord_type c[9];
      coord_type ext[4] = '{24'sh7fffff, 24'sh800000, 24'sh0, -24'sh1};
      // degenerate segment, point at start, point at end
      for (int i = 0; i < 9; i++) c[i] = 0;
      send_request(c, 0);
      c[0] = 5; c[1] = -7; c[2] = 3; send_request(c, 0);
      c = '{0, 0, 0, 0, 0, 0, 10, 0, 0}; send_request(c, 0);
      c = '{10, 0, 0, 0, 0, 0, 10, 0, 0}; send_request(c, 0);
      // projection exactly on the start and on the end, then inside, before and beyond
      c = '{0, 9, 0, 0, 0, 0, 10, 0, 0}; send_request(c, 0);
      c = '{10, 9, 0, 0, 0, 0, 10, 0, 0}; send_request(c, 0);
      c = '{5, 9, 4, 0, 0, 0, 10, 0, 0}; send_request(c, 0);
      c = '{-5, 3, 1, 0, 0, 0, 10, 0, 0}; send_request(c, 0);
      c = '{15, 3, 1, 0, 0, 0, 10, 0, 0}; send_request(c, 1);
      @(posedge clock);
      // coordinate extremes
      for (int k = 0; k < 12; k++) begin
         for (int i = 0; i < 9; i++) c[i] = ext[(i + k) % 4 ^ (i % 3 == k % 3)];
         send_request(c, k == 11);
      end
      @(posedge clock);
      c = '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000,
            24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000};
      send_request(c, 0);
      c = '{24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh800000,
            24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff};
      send_request(c, 1);
      @(posedge clock);
   endtask

   initial begin
      coord_type c[9];
      int burst, mode;
      error_count = 0;
      sent = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_directed();
      while (sent < 1700) begin
         burst = $urandom_range(1, 40);
         mode = $urandom_range(0, 3);
         for (int n = 0; n < burst; n++) begin
            for (int i = 0; i < 9; i++) c[i] = rand_coord(mode);
            if ($urandom_range(0, 7) == 0)
               for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
            send_request(c, n == burst - 1);
         end
         if (sent > 900 && sent < 960)
            while (sb.pending.size() != 0) @(posedge clock);
         else repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d requests, checked %0d results", sent, sb.checked);
      $display("covered start, end and interior parts, degenerate and extreme segments");
      if (error_count == 0)
         $display("tb_point_segment_distance_core: done, clean");
      else
         $display("tb_point_segment_distance_core: done, errors");
      $finish;
   end
endmodule
